// ===== sv/wsdm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsdm_pkg
// Types and constants shared by the wheel speed and trip distance meter.
// -----------------------------------------------------------------------------
package wsdm_pkg;

   localparam int CIRC_BITS     = 12;
   localparam int LOCKOUT_BITS  = 10;
   localparam int TIMEOUT_BITS  = 16;
   localparam int PERIOD_BITS   = 16;
   localparam int SPEED_BITS    = 15;
   localparam int DIST_BITS     = 32;
   localparam int DUR_BITS      = 24;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam int SCALE_BITS    = 9;
   localparam int PROD_BITS     = CIRC_BITS + SCALE_BITS;
   localparam int CNT_BITS      = $clog2(PROD_BITS);

   localparam logic [SCALE_BITS-1:0] CIRC_SCALE = 9'd360;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};
   localparam logic [DIST_BITS-1:0]  DIST_MAX  = {DIST_BITS{1'b1}};
   localparam logic [DUR_BITS-1:0]   DUR_MAX   = {DUR_BITS{1'b1}};

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CIRC    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOCKOUT = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIMEOUT = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PERIOD  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MINSPD  = 3'd4;

   localparam logic [CIRC_BITS-1:0]    CIRC_RST    = 12'd2155;
   localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RST = 10'd80;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 16'd3000;
   localparam logic [PERIOD_BITS-1:0]  PERIOD_RST  = 16'd1000;
   localparam logic [SPEED_BITS-1:0]   MINSPD_RST  = 15'd100;

   typedef logic [SPEED_BITS-1:0] speed_type;
   typedef logic [DIST_BITS-1:0]  dist_type;
   typedef logic [DUR_BITS-1:0]   dur_type;

endpackage

// ===== sv/wsdm_req_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsdm_req_if
// Tick channel: one item per millisecond tick.
// -----------------------------------------------------------------------------
interface wsdm_req_if;
   logic valid;
   logic ready;
   logic reed_pulse;
   logic trip_reset;

   modport source (output valid, reed_pulse, trip_reset, input ready);
   modport sink   (input valid, reed_pulse, trip_reset, output ready);
endinterface

// ===== sv/wsdm_rsp_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsdm_rsp_if
// Result channel: speed, distance, duration and tick flags.
// -----------------------------------------------------------------------------
interface wsdm_rsp_if;
   import wsdm_pkg::*;
   logic      valid;
   logic      ready;
   speed_type speed_centi_kmh;
   dist_type  distance_mm;
   dur_type   duration_s;
   logic      pulse_accepted;
   logic      stopped;

   modport source (output valid, speed_centi_kmh, distance_mm, duration_s,
                   pulse_accepted, stopped, input ready);
   modport sink   (input valid, speed_centi_kmh, distance_mm, duration_s,
                   pulse_accepted, stopped, output ready);
endinterface

// ===== sv/wsdm_csr_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsdm_csr_if
// Register write channel: register address and write data.
// -----------------------------------------------------------------------------
interface wsdm_csr_if;
   import wsdm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] addr;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/wheel_speed_distance_meter.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wheel_speed_distance_meter
// Wheel speed, trip distance and moving time from reed pulses per ms tick.
// -----------------------------------------------------------------------------
// req_ch carries one item per millisecond tick: reed_pulse and trip_reset.
// rsp_ch returns exactly one item per tick with speed (0.01 km/h), trip
// distance (mm, saturating), moving seconds (saturating) and tick flags.
// csr_ch writes the five settings (circumference, lockout, stop timeout,
// second period, moving threshold); it is always ready, writes to unknown
// addresses are dropped. Write it only while no tick is in flight.
// A tick without an accepted pulse passes from acceptance through the evaluate
// and final steps to rsp valid; a tick with an accepted pulse also passes
// through the restoring divider that forms circumference * 360 / dt one
// quotient bit per cycle. req_ch.ready is high only while the sequencer idles,
// so one tick is worked at a time.
// The result sits in an output register; the next tick is accepted while it
// waits, and that tick holds in its final step until rsp_ch.ready frees it.
// Synchronous reset restores default settings and clears time, speed,
// distance and duration.
// -----------------------------------------------------------------------------
module wheel_speed_distance_meter #(
   parameter int TIMESTAMP_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   wsdm_req_if.sink   req_ch,
   wsdm_rsp_if.source rsp_ch,
   wsdm_csr_if.sink   csr_ch
);
   import wsdm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   typedef logic [TIMESTAMP_BITS-1:0] ts_type;

   logic [1:0]              state_ff, state_in;
   logic [CIRC_BITS-1:0]    circ_ff, circ_in;
   logic [LOCKOUT_BITS-1:0] lockout_ff, lockout_in;
   logic [TIMEOUT_BITS-1:0] timeout_ff, timeout_in;
   logic [PERIOD_BITS-1:0]  period_ff, period_in;
   speed_type               minspd_ff, minspd_in;

   ts_type    now_ff, now_in;
   ts_type    last_pulse_ff, last_pulse_in;
   ts_type    last_sec_ff, last_sec_in;
   speed_type speed_ff, speed_in;
   dist_type  dist_ff, dist_in;
   dur_type   dur_ff, dur_in;

   logic pulse_ff, pulse_in;
   logic trip_ff, trip_in;
   logic acc_ff, acc_in;
   logic stop_ff, stop_in;
   logic sec_ff, sec_in;
   ts_type dt_ff, dt_in;

   logic [PROD_BITS-1:0] quo_ff, quo_in;
   ts_type               rem_ff, rem_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic      rsp_valid_ff, rsp_valid_in;
   speed_type rsp_speed_ff, rsp_speed_in;
   dist_type  rsp_dist_ff, rsp_dist_in;
   dur_type   rsp_dur_ff, rsp_dur_in;
   logic      rsp_acc_ff, rsp_acc_in;
   logic      rsp_stop_ff, rsp_stop_in;

   logic                  req_fire;
   logic                  fin_fire;
   ts_type                dt_now;
   ts_type                dt_sec;
   logic [TIMESTAMP_BITS:0] trial;
   logic [TIMESTAMP_BITS:0] trial_sub;
   speed_type             q_sat;
   speed_type             speed_new;
   logic [DIST_BITS:0]    dist_sum;
   dist_type              dist_new;
   dur_type               dur_new;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign fin_fire     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.speed_centi_kmh = rsp_speed_ff;
   assign rsp_ch.distance_mm     = rsp_dist_ff;
   assign rsp_ch.duration_s      = rsp_dur_ff;
   assign rsp_ch.pulse_accepted  = rsp_acc_ff;
   assign rsp_ch.stopped         = rsp_stop_ff;

   assign dt_now    = now_ff - last_pulse_ff;
   assign dt_sec    = now_ff - last_sec_ff;
   assign trial     = {rem_ff, quo_ff[PROD_BITS-1]};
   assign trial_sub = trial - {1'b0, dt_ff};

   assign q_sat = (quo_ff[PROD_BITS-1:SPEED_BITS] != '0) ? SPEED_MAX
                                                         : quo_ff[SPEED_BITS-1:0];

   always_comb begin
      speed_new = speed_ff;
      if (trip_ff || stop_ff) begin
         speed_new = '0;
      end else if (acc_ff) begin
         speed_new = q_sat;
      end
   end

   assign dist_sum = {1'b0, dist_ff} + (DIST_BITS + 1)'(circ_ff);

   always_comb begin
      dist_new = dist_ff;
      if (trip_ff) begin
         dist_new = '0;
      end else if (acc_ff) begin
         dist_new = dist_sum[DIST_BITS] ? DIST_MAX : dist_sum[DIST_BITS-1:0];
      end
   end

   always_comb begin
      dur_new = trip_ff ? '0 : dur_ff;
      if (sec_ff && (speed_new > minspd_ff) && (dur_new != DUR_MAX)) begin
         dur_new = dur_new + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      circ_in       = circ_ff;
      lockout_in    = lockout_ff;
      timeout_in    = timeout_ff;
      period_in     = period_ff;
      minspd_in     = minspd_ff;
      now_in        = now_ff;
      last_pulse_in = last_pulse_ff;
      last_sec_in   = last_sec_ff;
      speed_in      = speed_ff;
      dist_in       = dist_ff;
      dur_in        = dur_ff;
      pulse_in      = pulse_ff;
      trip_in       = trip_ff;
      acc_in        = acc_ff;
      stop_in       = stop_ff;
      sec_in        = sec_ff;
      dt_in         = dt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_speed_in  = rsp_speed_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_dur_in    = rsp_dur_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_stop_in   = rsp_stop_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            CSR_CIRC:    circ_in    = csr_ch.data[CIRC_BITS-1:0];
            CSR_LOCKOUT: lockout_in = csr_ch.data[LOCKOUT_BITS-1:0];
            CSR_TIMEOUT: timeout_in = csr_ch.data[TIMEOUT_BITS-1:0];
            CSR_PERIOD:  period_in  = csr_ch.data[PERIOD_BITS-1:0];
            CSR_MINSPD:  minspd_in  = csr_ch.data[SPEED_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pulse_in = req_ch.reed_pulse;
               trip_in  = req_ch.trip_reset;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            dt_in   = dt_now;
            acc_in  = pulse_ff && !trip_ff && (dt_now > TIMESTAMP_BITS'(lockout_ff));
            stop_in = !(pulse_ff && !trip_ff && (dt_now > TIMESTAMP_BITS'(lockout_ff)))
                      && !trip_ff && (dt_now > TIMESTAMP_BITS'(timeout_ff));
            sec_in  = dt_sec > TIMESTAMP_BITS'(period_ff);
            quo_in  = PROD_BITS'(circ_ff) * PROD_BITS'(CIRC_SCALE);
            rem_in  = '0;
            cnt_in  = CNT_BITS'(PROD_BITS - 1);
            state_in = (pulse_ff && !trip_ff && (dt_now > TIMESTAMP_BITS'(lockout_ff)))
                       ? S_DIV : S_FIN;
         end
         S_DIV: begin
            if (trial >= {1'b0, dt_ff}) begin
               rem_in = trial_sub[TIMESTAMP_BITS-1:0];
               quo_in = {quo_ff[PROD_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[TIMESTAMP_BITS-1:0];
               quo_in = {quo_ff[PROD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_fire) begin
               speed_in = speed_new;
               dist_in  = dist_new;
               dur_in   = dur_new;
               if (acc_ff || trip_ff) begin
                  last_pulse_in = now_ff;
               end
               if (sec_ff) begin
                  last_sec_in = now_ff;
               end
               now_in       = now_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_new;
               rsp_dist_in  = dist_new;
               rsp_dur_in   = dur_new;
               rsp_acc_in   = acc_ff;
               rsp_stop_in  = stop_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         circ_ff       <= CIRC_RST;
         lockout_ff    <= LOCKOUT_RST;
         timeout_ff    <= TIMEOUT_RST;
         period_ff     <= PERIOD_RST;
         minspd_ff     <= MINSPD_RST;
         now_ff        <= '0;
         last_pulse_ff <= '0;
         last_sec_ff   <= '0;
         speed_ff      <= '0;
         dist_ff       <= '0;
         dur_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         circ_ff       <= circ_in;
         lockout_ff    <= lockout_in;
         timeout_ff    <= timeout_in;
         period_ff     <= period_in;
         minspd_ff     <= minspd_in;
         now_ff        <= now_in;
         last_pulse_ff <= last_pulse_in;
         last_sec_ff   <= last_sec_in;
         speed_ff      <= speed_in;
         dist_ff       <= dist_in;
         dur_ff        <= dur_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pulse_ff     <= pulse_in;
      trip_ff      <= trip_in;
      acc_ff       <= acc_in;
      stop_ff      <= stop_in;
      sec_ff       <= sec_in;
      dt_ff        <= dt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_dur_ff   <= rsp_dur_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_stop_ff  <= rsp_stop_in;
   end

endmodule

// ===== sv/wsdm_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wsdm_checker
// Port-level checks for the wheel speed and trip distance meter.
// -----------------------------------------------------------------------------
module wsdm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input wsdm_pkg::speed_type rsp_speed,
   input wsdm_pkg::dist_type  rsp_dist,
   input logic                rsp_acc,
   input logic                rsp_stop
);
   import wsdm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_speed) && $stable(rsp_dist))
      else $error("rsp payload changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second tick taken before the first finished");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_acc && rsp_stop))
      else $error("pulse accepted and stopped in one tick");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop |-> rsp_speed == '0)
      else $error("stopped with nonzero speed");

endmodule

bind wheel_speed_distance_meter wsdm_checker u_wsdm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_speed (rsp_ch.speed_centi_kmh),
   .rsp_dist  (rsp_ch.distance_mm),
   .rsp_acc   (rsp_ch.pulse_accepted),
   .rsp_stop  (rsp_ch.stopped)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wheel speed and trip distance meter.
// -----------------------------------------------------------------------------
// Sends millisecond tick items that carry reed pulses and trip resets, and
// writes the five settings between phases while the block is idle. A
// tick-level tracker of speed, distance and moving time predicts one reading
// per tick. Every returned reading is checked field by field against the
// oldest prediction. Random phases vary the settings, including the extremes,
// and apply sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module tb_top;
   import wsdm_pkg::*;

   localparam int TS_BITS         = 32;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RAND_PHASES     = 8;
   localparam int TICKS_PER_PHASE = 215;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOP = CSR_ADDR_BITS'(2**CSR_ADDR_BITS - 1);

   typedef struct packed {
      speed_type speed_centi_kmh;
      dist_type  distance_mm;
      dur_type   duration_s;
      logic      pulse_accepted;
      logic      stopped;
   } reading_type;

   class meter_tracker;
      logic [CIRC_BITS-1:0]    circ;
      logic [LOCKOUT_BITS-1:0] lockout;
      logic [TIMEOUT_BITS-1:0] timeout;
      logic [PERIOD_BITS-1:0]  period;
      logic [SPEED_BITS-1:0]   min_speed;
      logic [TS_BITS-1:0]      now_ms, last_pulse_ms, last_second_ms;
      speed_type   speed;
      dist_type    distance;
      dur_type     duration;
      reading_type pending[$];
      int unsigned mismatches;

      function new();
         circ           = CIRC_RST;
         lockout        = LOCKOUT_RST;
         timeout        = TIMEOUT_RST;
         period         = PERIOD_RST;
         min_speed      = MINSPD_RST;
         now_ms         = '0;
         last_pulse_ms  = '0;
         last_second_ms = '0;
         speed          = '0;
         distance       = '0;
         duration       = '0;
         mismatches     = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] d);
         case (idx)
            CSR_CIRC:    circ      = d[CIRC_BITS-1:0];
            CSR_LOCKOUT: lockout   = d[LOCKOUT_BITS-1:0];
            CSR_TIMEOUT: timeout   = d[TIMEOUT_BITS-1:0];
            CSR_PERIOD:  period    = d[PERIOD_BITS-1:0];
            CSR_MINSPD:  min_speed = d[SPEED_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void log_tick(logic pulse, logic trip_clear);
         logic [TS_BITS-1:0] t, dt;
         logic [31:0]        q;
         logic [DIST_BITS:0] sum;
         reading_type        r;
         t = now_ms;
         r = '0;
         if (pulse && !trip_clear) begin
            dt = t - last_pulse_ms;
            if (dt > lockout) begin
               q = (32'(circ) * 32'd360) / dt;
               speed = (q > 32'(SPEED_MAX)) ? SPEED_MAX : q[SPEED_BITS-1:0];
               sum = {1'b0, distance} + (DIST_BITS + 1)'(circ);
               distance = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
               last_pulse_ms = t;
               r.pulse_accepted = 1'b1;
            end
         end
         if (trip_clear) begin
            speed         = '0;
            distance      = '0;
            duration      = '0;
            last_pulse_ms = t;
         end
         if (TS_BITS'(t - last_pulse_ms) > timeout) begin
            speed     = '0;
            r.stopped = 1'b1;
         end
         if (TS_BITS'(t - last_second_ms) > period) begin
            if (speed > min_speed && duration != DUR_MAX)
               duration = duration + 1'b1;
            last_second_ms = t;
         end
         now_ms = t + 1'b1;
         r.speed_centi_kmh = speed;
         r.distance_mm     = distance;
         r.duration_s      = duration;
         pending.push_back(r);
      endfunction

      function void compare(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected reading, expected none, got %p", $time, got);
            return;
         end
         want = pending.pop_front();
         compare("speed_centi_kmh", want.speed_centi_kmh, got.speed_centi_kmh);
         compare("distance_mm", want.distance_mm, got.distance_mm);
         compare("duration_s", want.duration_s, got.duration_s);
         compare("pulse_accepted", want.pulse_accepted, got.pulse_accepted);
         compare("stopped", want.stopped, got.stopped);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   quiet_cycles;
   meter_tracker meter;

   wsdm_req_if req_ch ();
   wsdm_rsp_if rsp_ch ();
   wsdm_csr_if csr_ch ();

   wheel_speed_distance_meter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         meter.check_reading('{rsp_ch.speed_centi_kmh, rsp_ch.distance_mm, rsp_ch.duration_s,
                               rsp_ch.pulse_accepted, rsp_ch.stopped});
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic pulse, input logic trip_clear);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.reed_pulse <= pulse;
      req_ch.trip_reset <= trip_clear;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      meter.log_tick(pulse, trip_clear);
   endtask

   // drop valid, let all readings return, then let the pipeline empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (meter.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // upper bits beyond the register width are random and must be masked
   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input int unsigned value,
                            input int width);
      logic [CSR_DATA_BITS-1:0] d;
      d = CSR_DATA_BITS'(($urandom() << width) | value);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.data  <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      meter.set_reg(idx, d);
   endtask

   task automatic apply_settings(input int unsigned circ, input int unsigned lockout,
                                 input int unsigned timeout, input int unsigned period,
                                 input int unsigned min_speed, input bit stray);
      write_reg(CSR_CIRC, circ, CIRC_BITS);
      write_reg(CSR_LOCKOUT, lockout, LOCKOUT_BITS);
      write_reg(CSR_TIMEOUT, timeout, TIMEOUT_BITS);
      write_reg(CSR_PERIOD, period, PERIOD_BITS);
      write_reg(CSR_MINSPD, min_speed, SPEED_BITS);
      if (stray)
         write_reg(CSR_ADDR_BITS'($urandom_range(CSR_MINSPD + 1, CSR_TOP)), $urandom(), 0);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic int unsigned pick(int unsigned lo_val, int unsigned hi_val,
                                        int unsigned lo_rng, int unsigned hi_rng);
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return lo_val;
      if (r == 1) return hi_val;
      return $urandom_range(lo_rng, hi_rng);
   endfunction

   initial begin
      int unsigned lockout_now, timeout_now, gap, span;
      logic        pulse, trip_clear;
      meter     = new();
      idle_pct  = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.reed_pulse <= 1'b0;
      req_ch.trip_reset <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.addr       <= '0;
      csr_ch.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: pulse at time zero is locked out, reset beats pulse
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);

      // largest wheel, no lockout: speed saturates, zero timeout stops at once
      settle();
      apply_settings(4095, 0, 0, 0, 0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);

      // zero circumference, maximum lockout, timeout, period and threshold
      settle();
      apply_settings(0, 1023, 65535, 65535, 32767, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);

      settle();
      write_reg(CSR_LOCKOUT, 0, LOCKOUT_BITS);
      csr_ch.valid <= 1'b0;
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         lockout_now = pick(0, 1023, 1, 40);
         timeout_now = pick(0, 65535, 20, 160);
         apply_settings(pick(0, 4095, 1000, 4000), lockout_now, timeout_now,
                        pick(0, 65535, 1, 50), pick(0, 32767, 0, 17777), ph % 3 == 0);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         gap = 0;
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (ph == 1 && n % 50 == 25) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (meter.pending.size() != 0) @(posedge clock);
            end
            if (gap == 0) begin
               pulse = 1'b1;
               span  = 3 + lockout_now / 2;
               case ($urandom_range(9))
                  0: gap = (lockout_now > 0) ? $urandom_range(0, lockout_now - 1) : 0;
                  1: gap = (timeout_now < 200) ? timeout_now + $urandom_range(0, 4)
                                               : $urandom_range(lockout_now, lockout_now + span);
                  default: gap = $urandom_range(lockout_now, lockout_now + span);
               endcase
            end else begin
               pulse = ($urandom_range(49) == 0);
               gap--;
            end
            trip_clear = ($urandom_range(79) == 0);
            send_tick(pulse, trip_clear);
         end
      end

      req_ch.valid <= 1'b0;
      while (meter.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (meter.pending.size() != 0) begin
         meter.mismatches++;
         $display("%0t: readings expected %0d more, got none", $time, meter.pending.size());
      end
      if (meter.mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule

// ===== wheel_speed_distance_meter.f =====
sv/wsdm_pkg.sv
sv/wsdm_req_if.sv
sv/wsdm_rsp_if.sv
sv/wsdm_csr_if.sv
sv/wheel_speed_distance_meter.sv
sv/wsdm_checker.sv
sim/tb_top.sv
